// ===== src/qarma_pkg.sv =====
// shared types, constants and cell functions for the qarma-64 encrypt pipeline
// no dependencies
package qarma_pkg;

  typedef logic [63:0] blk_t;
  typedef logic [3:0]  nib_t;
  typedef nib_t        perm_t [16];

  localparam int RC_DEPTH = 16;

  localparam logic [2:0] CFG_W0     = 3'd0;
  localparam logic [2:0] CFG_W1     = 3'd1;
  localparam logic [2:0] CFG_CORE   = 3'd2;
  localparam logic [2:0] CFG_MIDDLE = 3'd3;
  localparam logic [2:0] CFG_ROUNDS = 3'd4;

  localparam nib_t  SBOX     [16] = '{4'd0, 4'd14, 4'd2, 4'd10, 4'd9, 4'd15, 4'd8, 4'd11,
                                      4'd6, 4'd4, 4'd3, 4'd7, 4'd13, 4'd12, 4'd1, 4'd5};
  localparam perm_t SHUF_FWD = '{4'd0, 4'd11, 4'd6, 4'd13, 4'd10, 4'd1, 4'd12, 4'd7,
                                  4'd5, 4'd14, 4'd3, 4'd8, 4'd15, 4'd4, 4'd9, 4'd2};
  localparam perm_t SHUF_BWD = '{4'd0, 4'd5, 4'd15, 4'd10, 4'd13, 4'd8, 4'd2, 4'd7,
                                  4'd11, 4'd14, 4'd4, 4'd1, 4'd6, 4'd3, 4'd9, 4'd12};
  localparam perm_t TWK_FWD  = '{4'd6, 4'd5, 4'd14, 4'd15, 4'd0, 4'd1, 4'd2, 4'd3,
                                  4'd7, 4'd12, 4'd13, 4'd4, 4'd8, 4'd9, 4'd10, 4'd11};
  localparam perm_t TWK_BWD  = '{4'd4, 4'd5, 4'd6, 4'd7, 4'd11, 4'd1, 4'd0, 4'd8,
                                  4'd12, 4'd13, 4'd14, 4'd15, 4'd9, 4'd10, 4'd2, 4'd3};
  // cells that carry the tweak lfsr
  localparam logic [15:0] LFSR_MASK = 16'b1101_1000_1001_0100;

  localparam blk_t ROUND_CONST [RC_DEPTH] = '{
    64'h0000000000000000, 64'h13198A2E03707344, 64'hA4093822299F31D0,
    64'h082EFA98EC4E6C89, 64'h452821E638D01377, 64'hBE5466CF34E90C6C,
    64'h3F84D5B5B5470917, 64'h9216D5D98979FB1B, 64'hD1310BA698DFB5AC,
    64'h2FFD72DBD01ADFB7, 64'hB8E1AFED6A267E96, 64'hBA7C9045F12C7F99,
    64'h24A19947B3916CF7, 64'h0801F2E2858EFC16, 64'h636920D871574E69,
    64'hA458FEA3F4933D7E};
  localparam blk_t ALPHA = 64'hC0AC29B7C97C50DD;

  function automatic nib_t get_cell(input blk_t v, input int i);
    return v[63-4*i -: 4];
  endfunction

  function automatic blk_t permute(input blk_t v, input perm_t p);
    blk_t r;
    for (int i = 0; i < 16; i++) begin
      r[63-4*i -: 4] = get_cell(v, int'(p[i]));
    end
    return r;
  endfunction

  function automatic blk_t subcells(input blk_t v);
    blk_t r;
    for (int i = 0; i < 16; i++) begin
      r[63-4*i -: 4] = SBOX[get_cell(v, i)];
    end
    return r;
  endfunction

  function automatic nib_t rot1(input nib_t v);
    return {v[2:0], v[3]};
  endfunction

  function automatic nib_t rot2(input nib_t v);
    return {v[1:0], v[3:2]};
  endfunction

  function automatic blk_t mix(input blk_t v);
    blk_t r;
    nib_t s0, s1, s2, s3;
    for (int j = 0; j < 4; j++) begin
      s0 = get_cell(v, j);
      s1 = get_cell(v, j + 4);
      s2 = get_cell(v, j + 8);
      s3 = get_cell(v, j + 12);
      r[63-4*j -: 4]      = rot1(s1) ^ rot2(s2) ^ rot1(s3);
      r[63-4*(j+4) -: 4]  = rot1(s0) ^ rot1(s2) ^ rot2(s3);
      r[63-4*(j+8) -: 4]  = rot2(s0) ^ rot1(s1) ^ rot1(s3);
      r[63-4*(j+12) -: 4] = rot1(s0) ^ rot2(s1) ^ rot1(s2);
    end
    return r;
  endfunction

  function automatic blk_t tweak_fwd(input blk_t v);
    blk_t r;
    nib_t c;
    r = permute(v, TWK_FWD);
    for (int i = 0; i < 16; i++) begin
      c = get_cell(r, i);
      if (LFSR_MASK[15-i]) begin
        r[63-4*i -: 4] = {c[0] ^ c[1], c[3:1]};
      end
    end
    return r;
  endfunction

  function automatic blk_t tweak_bwd(input blk_t v);
    blk_t r;
    nib_t c;
    r = v;
    for (int i = 0; i < 16; i++) begin
      c = get_cell(v, i);
      if (LFSR_MASK[15-i]) begin
        r[63-4*i -: 4] = {c[2:0], c[0] ^ c[3]};
      end
    end
    return permute(r, TWK_BWD);
  endfunction

endpackage

// ===== src/qarma64_tweakable_encrypt_core.sv =====
// qarma-64 tweakable encryption core, top level
// depends on qarma_pkg, qarma_fwd_cell, qarma_refl_cell, qarma_bwd_cell
//
// Takes one request per clock and never stalls: busy stays low, so a request
// is accepted on every edge where in_start is high. Each request walks a row
// of 2*MAX_ROUNDS+1 cells (forward rounds, the reflector, backward rounds),
// one cell per cycle, and its ciphertext appears on out_ciphertext with
// out_valid high for one cycle once it has left the last backward cell,
// whatever round_count holds; cells beyond the programmed count pass the
// data through. The receiver cannot hold results off. Keys and the round
// count are written through the cfg_ channel (always ready) and must only
// change while no request is in flight. A round_count above MAX_ROUNDS is
// treated as MAX_ROUNDS; zero leaves only whitening and the reflector.
module qarma64_tweakable_encrypt_core import qarma_pkg::*; #(
  parameter int MAX_ROUNDS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_start,
  output logic        busy,
  input  logic [63:0] in_plaintext,
  input  logic [63:0] in_tweak_value,
  output logic        out_valid,
  output logic [63:0] out_ciphertext,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int LAT = 2 * MAX_ROUNDS + 1;

  // configuration registers
  blk_t       w0_r, w1_r, core_r, middle_r;
  logic [4:0] rounds_r;
  logic [4:0] rounds_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w0_r     <= '0;
      w1_r     <= '0;
      core_r   <= '0;
      middle_r <= '0;
      rounds_r <= 5'd7;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_W0:     w0_r     <= cfg_data;
        CFG_W1:     w1_r     <= cfg_data;
        CFG_CORE:   core_r   <= cfg_data;
        CFG_MIDDLE: middle_r <= cfg_data;
        CFG_ROUNDS: rounds_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready  = 1'b1;
  assign busy       = 1'b0;
  assign rounds_sat = (rounds_r > 5'(MAX_ROUNDS)) ? 5'(MAX_ROUNDS) : rounds_r;

  logic accept;
  assign accept = in_start && !busy;

  // forward chain, entry carries the initial whitening
  logic fv [MAX_ROUNDS+1];
  blk_t fs [MAX_ROUNDS+1];
  blk_t ft [MAX_ROUNDS+1];

  assign fv[0] = accept;
  assign fs[0] = in_plaintext ^ w0_r;
  assign ft[0] = in_tweak_value;

  for (genvar g = 0; g < MAX_ROUNDS; g++) begin : g_fwd
    qarma_fwd_cell #(.IDX(g)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .valid_i(fv[g]), .state_i(fs[g]), .tweak_i(ft[g]),
      .rounds(rounds_sat), .round_key(core_r),
      .valid_o(fv[g+1]), .state_o(fs[g+1]), .tweak_o(ft[g+1])
    );
  end

  // backward chain, element 0 fed by the reflector
  logic bv [MAX_ROUNDS+1];
  blk_t bs [MAX_ROUNDS+1];
  blk_t bt [MAX_ROUNDS+1];

  qarma_refl_cell u_refl (
    .clk(clk), .rst_n(rst_n),
    .valid_i(fv[MAX_ROUNDS]), .state_i(fs[MAX_ROUNDS]), .tweak_i(ft[MAX_ROUNDS]),
    .w0(w0_r), .w1(w1_r), .refl_key(middle_r),
    .valid_o(bv[0]), .state_o(bs[0]), .tweak_o(bt[0])
  );

  // backward cell k handles the round with constant index MAX_ROUNDS-1-k;
  // active cells sit at the end of the chain
  for (genvar g = 0; g < MAX_ROUNDS; g++) begin : g_bwd
    qarma_bwd_cell #(.CIDX(MAX_ROUNDS - 1 - g)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .valid_i(bv[g]), .state_i(bs[g]), .tweak_i(bt[g]),
      .rounds(rounds_sat), .round_key(core_r),
      .valid_o(bv[g+1]), .state_o(bs[g+1]), .tweak_o(bt[g+1])
    );
  end

  // final whitening
  assign out_valid      = bv[MAX_ROUNDS];
  assign out_ciphertext = bs[MAX_ROUNDS] ^ w1_r;

  // a result only leaves for a request that was accepted and has passed every cell of the row
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result without matching request");

  // the reflector output carries a request only once it has passed every forward cell and the reflector
  a_refl_origin: assert property (@(posedge clk) disable iff (!rst_n)
    bv[0] |-> $past(accept, MAX_ROUNDS + 1))
    else $error("reflector stage out of step");

  // the saturated round count never exceeds the cell count
  a_rounds_sat: assert property (@(posedge clk) disable iff (!rst_n)
    rounds_sat <= 5'(MAX_ROUNDS))
    else $error("round count above cell count");

endmodule

// ===== src/qarma_fwd_cell.sv =====
// one forward round cell of the encrypt pipeline
// depends on qarma_pkg
module qarma_fwd_cell import qarma_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       valid_i,
  input  blk_t       state_i,
  input  blk_t       tweak_i,
  input  logic [4:0] rounds,
  input  blk_t       round_key,
  output logic       valid_o,
  output blk_t       state_o,
  output blk_t       tweak_o
);

  localparam logic [4:0] RIDX = 5'(IDX);

  logic valid_r;
  blk_t state_r, state_nxt, tweak_r, tweak_nxt;

  always_comb begin
    blk_t x;
    x = state_i ^ ROUND_CONST[IDX % RC_DEPTH] ^ round_key ^ tweak_i;
    if (IDX != 0) begin
      x = mix(permute(x, SHUF_FWD));
    end
    x = subcells(x);
    if (RIDX < rounds) begin
      state_nxt = x;
      tweak_nxt = tweak_fwd(tweak_i);
    end else begin
      state_nxt = state_i;
      tweak_nxt = tweak_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
    tweak_r <= tweak_nxt;
  end

  assign valid_o = valid_r;
  assign state_o = state_r;
  assign tweak_o = tweak_r;

endmodule

// ===== src/qarma_refl_cell.sv =====
// central reflector cell of the encrypt pipeline
// depends on qarma_pkg
module qarma_refl_cell import qarma_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic valid_i,
  input  blk_t state_i,
  input  blk_t tweak_i,
  input  blk_t w0,
  input  blk_t w1,
  input  blk_t refl_key,
  output logic valid_o,
  output blk_t state_o,
  output blk_t tweak_o
);

  logic valid_r;
  blk_t state_r, state_nxt, tweak_r;

  always_comb begin
    blk_t x;
    x = state_i ^ w1 ^ tweak_i;
    x = subcells(mix(permute(x, SHUF_FWD)));
    x = mix(permute(x, SHUF_FWD)) ^ refl_key;
    x = subcells(permute(x, SHUF_BWD));
    x = permute(mix(x), SHUF_BWD);
    state_nxt = x ^ w0 ^ tweak_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
    tweak_r <= tweak_i;
  end

  assign valid_o = valid_r;
  assign state_o = state_r;
  assign tweak_o = tweak_r;

endmodule

// ===== src/qarma_bwd_cell.sv =====
// one backward round cell, handling the round with constant index CIDX
// depends on qarma_pkg
module qarma_bwd_cell import qarma_pkg::*; #(
  parameter int CIDX = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       valid_i,
  input  blk_t       state_i,
  input  blk_t       tweak_i,
  input  logic [4:0] rounds,
  input  blk_t       round_key,
  output logic       valid_o,
  output blk_t       state_o,
  output blk_t       tweak_o
);

  localparam logic [4:0] RIDX = 5'(CIDX);

  logic valid_r;
  blk_t state_r, state_nxt, tweak_r, tweak_nxt;

  always_comb begin
    blk_t x, tn;
    tn = tweak_bwd(tweak_i);
    x = subcells(state_i);
    // last backward round skips mix and shuffle
    if (CIDX != 0) begin
      x = permute(mix(x), SHUF_BWD);
    end
    x = x ^ tn ^ round_key ^ ALPHA ^ ROUND_CONST[CIDX % RC_DEPTH];
    if (RIDX < rounds) begin
      state_nxt = x;
      tweak_nxt = tn;
    end else begin
      state_nxt = state_i;
      tweak_nxt = tweak_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
    tweak_r <= tweak_nxt;
  end

  assign valid_o = valid_r;
  assign state_o = state_r;
  assign tweak_o = tweak_r;

endmodule

// ===== tb/tb_qarma64_tweakable_encrypt_core.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the qarma-64 tweakable encryption core
// depends on qarma_pkg (register indexes) and qarma64_tweakable_encrypt_core
module tb_qarma64_tweakable_encrypt_core;
  import qarma_pkg::*;

  localparam int NROUNDS = 16;
  localparam int LATENCY = 2 * NROUNDS + 1;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [63:0] plaintext;
    logic [63:0] tweak;
  } request_t;

  logic clk, rst_n;
  logic in_start, busy;
  logic [63:0] in_plaintext, in_tweak_value;
  logic out_valid;
  logic [63:0] out_ciphertext;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;

  qarma64_tweakable_encrypt_core #(.MAX_ROUNDS(NROUNDS)) dut (
    .clk(clk), .rst_n(rst_n), .in_start(in_start), .busy(busy),
    .in_plaintext(in_plaintext), .in_tweak_value(in_tweak_value),
    .out_valid(out_valid), .out_ciphertext(out_ciphertext),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor copy of the key registers
  logic [63:0] key_w0, key_w1, key_core, key_mid;
  logic [4:0]  rounds_reg;

  request_t    pending_requests[$];
  logic [63:0] expected_cipher[$];
  int mismatches, checked, accepted, cycles;
  bit noidle;
  int gap_left;

  // cipher tables, kept local to the predictor
  localparam logic [3:0] SB [16] = '{0, 14, 2, 10, 9, 15, 8, 11, 6, 4, 3, 7, 13, 12, 1, 5};
  localparam logic [3:0] SHF [16] = '{0, 11, 6, 13, 10, 1, 12, 7, 5, 14, 3, 8, 15, 4, 9, 2};
  localparam logic [3:0] SHB [16] = '{0, 5, 15, 10, 13, 8, 2, 7, 11, 14, 4, 1, 6, 3, 9, 12};
  localparam logic [3:0] TWF [16] = '{6, 5, 14, 15, 0, 1, 2, 3, 7, 12, 13, 4, 8, 9, 10, 11};
  localparam logic [3:0] TWB [16] = '{4, 5, 6, 7, 11, 1, 0, 8, 12, 13, 14, 15, 9, 10, 2, 3};
  localparam logic [63:0] RCON [16] = '{
    64'h0000000000000000, 64'h13198A2E03707344, 64'hA4093822299F31D0,
    64'h082EFA98EC4E6C89, 64'h452821E638D01377, 64'hBE5466CF34E90C6C,
    64'h3F84D5B5B5470917, 64'h9216D5D98979FB1B, 64'hD1310BA698DFB5AC,
    64'h2FFD72DBD01ADFB7, 64'hB8E1AFED6A267E96, 64'hBA7C9045F12C7F99,
    64'h24A19947B3916CF7, 64'h0801F2E2858EFC16, 64'h636920D871574E69,
    64'hA458FEA3F4933D7E};
  localparam logic [63:0] ALPHA_C = 64'hC0AC29B7C97C50DD;

  typedef logic [3:0] cells_t [16];

  function automatic cells_t to_cells(logic [63:0] v);
    cells_t c;
    for (int i = 0; i < 16; i++) c[i] = v[63-4*i -: 4];
    return c;
  endfunction

  function automatic logic [63:0] from_cells(cells_t c);
    logic [63:0] v;
    for (int i = 0; i < 16; i++) v[63-4*i -: 4] = c[i];
    return v;
  endfunction

  function automatic cells_t reorder(cells_t c, logic [3:0] p [16]);
    cells_t t;
    for (int i = 0; i < 16; i++) t[i] = c[p[i]];
    return t;
  endfunction

  function automatic cells_t sbox_all(cells_t c);
    for (int i = 0; i < 16; i++) c[i] = SB[c[i]];
    return c;
  endfunction

  function automatic logic [3:0] rl(logic [3:0] v, int n);
    return 4'((v << n) | (v >> (4 - n)));
  endfunction

  function automatic cells_t mix_cols(cells_t c);
    cells_t t;
    for (int j = 0; j < 4; j++) begin
      t[j]    = rl(c[j+4], 1) ^ rl(c[j+8], 2) ^ rl(c[j+12], 1);
      t[j+4]  = rl(c[j], 1) ^ rl(c[j+8], 1) ^ rl(c[j+12], 2);
      t[j+8]  = rl(c[j], 2) ^ rl(c[j+4], 1) ^ rl(c[j+12], 1);
      t[j+12] = rl(c[j], 1) ^ rl(c[j+4], 2) ^ rl(c[j+8], 1);
    end
    return t;
  endfunction

  function automatic bit lfsr_cell(int i);
    return i == 0 || i == 1 || i == 3 || i == 4 || i == 8 || i == 11 || i == 13;
  endfunction

  function automatic cells_t tweak_step_fwd(cells_t t);
    logic [3:0] v;
    t = reorder(t, TWF);
    for (int i = 0; i < 16; i++)
      if (lfsr_cell(i)) begin
        v = t[i];
        t[i] = {v[0] ^ v[1], v[3:1]};
      end
    return t;
  endfunction

  function automatic cells_t tweak_step_bwd(cells_t t);
    logic [3:0] v;
    for (int i = 0; i < 16; i++)
      if (lfsr_cell(i)) begin
        v = t[i];
        t[i] = {v[2:0], v[0] ^ v[3]};
      end
    return reorder(t, TWB);
  endfunction

  function automatic cells_t xor_blk(cells_t c, logic [63:0] k);
    return to_cells(from_cells(c) ^ k);
  endfunction

  // full encryption with the current key registers
  function automatic logic [63:0] encrypt_block(logic [63:0] pt, logic [63:0] tw);
    cells_t s, t;
    int r;
    r = (rounds_reg > NROUNDS) ? NROUNDS : int'(rounds_reg);
    s = to_cells(pt ^ key_w0);
    t = to_cells(tw);
    for (int i = 0; i < r; i++) begin
      s = xor_blk(s, RCON[i] ^ key_core ^ from_cells(t));
      if (i != 0) s = mix_cols(reorder(s, SHF));
      s = sbox_all(s);
      t = tweak_step_fwd(t);
    end
    // central reflector
    s = xor_blk(s, key_w1 ^ from_cells(t));
    s = sbox_all(mix_cols(reorder(s, SHF)));
    s = mix_cols(reorder(s, SHF));
    s = xor_blk(s, key_mid);
    s = mix_cols(sbox_all(reorder(s, SHB)));
    s = reorder(s, SHB);
    s = xor_blk(s, key_w0 ^ from_cells(t));
    for (int i = 0; i < r; i++) begin
      t = tweak_step_bwd(t);
      s = sbox_all(s);
      if (i + 1 != r) s = reorder(mix_cols(s), SHB);
      s = xor_blk(s, from_cells(t) ^ key_core ^ ALPHA_C ^ RCON[r-1-i]);
    end
    return from_cells(s) ^ key_w1;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // driver: one request per accept edge, random idle bursts unless noidle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_start && !busy) begin
        expected_cipher.push_back(encrypt_block(in_plaintext, in_tweak_value));
        accepted <= accepted + 1;
      end
      if (in_start && busy) begin
        // hold the request until accepted
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_start <= 1'b0;
      end else if (!noidle && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 4);
        in_start <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        in_start <= 1'b1;
        {in_plaintext, in_tweak_value} <= pending_requests.pop_front();
      end else begin
        in_start <= 1'b0;
      end
    end
  end

  // monitor: compare each ciphertext with the oldest expectation
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (expected_cipher.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected ciphertext %h", out_ciphertext);
      end else begin
        if (expected_cipher[0] !== out_ciphertext) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("ciphertext mismatch: expected %h got %h",
                     expected_cipher[0], out_ciphertext);
        end
        void'(expected_cipher.pop_front());
        checked <= checked + 1;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_W0:     key_w0 = val;
      CFG_W1:     key_w1 = val;
      CFG_CORE:   key_core = val;
      CFG_MIDDLE: key_mid = val;
      CFG_ROUNDS: rounds_reg = val[4:0];
      default: ;
    endcase
  endtask

  // block until every queued request is out and checked
  task automatic drain();
    while (pending_requests.size() > 0 || in_start || expected_cipher.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_random(int n);
    request_t rq;
    for (int i = 0; i < n; i++) begin
      rq.plaintext = rand64();
      rq.tweak = rand64();
      pending_requests.push_back(rq);
    end
  endtask

  initial begin
    logic [4:0] rsel;
    rst_n = 1'b0;
    in_start = 1'b0;
    in_plaintext = '0;
    in_tweak_value = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_W0;
    cfg_data = '0;
    key_w0 = '0; key_w1 = '0; key_core = '0; key_mid = '0; rounds_reg = 5'd7;
    mismatches = 0; checked = 0; accepted = 0; cycles = 0; noidle = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset keys and field extremes
    pending_requests.push_back('{64'h0, 64'h0});
    pending_requests.push_back('{'1, '1});
    pending_requests.push_back('{'1, 64'h0});
    pending_requests.push_back('{64'h0, '1});
    pending_requests.push_back('{64'h0123456789ABCDEF, 64'hFEDCBA9876543210});
    drain();

    // directed: zero rounds, one round, maximum and saturated counts
    cfg_write(CFG_W0, 64'h84BE85CE9804E94B);
    cfg_write(CFG_W1, 64'hEC2802D4E0A488E9);
    cfg_write(CFG_CORE, 64'hAAAAAAAAAAAAAAAA);
    cfg_write(CFG_MIDDLE, '1);
    for (int k = 0; k < 5; k++) begin
      rsel = (k == 0) ? 5'd0 : (k == 1) ? 5'd1 : (k == 2) ? 5'd16 : (k == 3) ? 5'd17 : 5'd31;
      cfg_write(CFG_ROUNDS, 64'(rsel));
      pending_requests.push_back('{64'hFB623599DA6E8127, 64'h477D469DEC0B8762});
      pending_requests.push_back('{'1, 64'h0});
      pending_requests.push_back('{rand64(), rand64()});
      drain();
    end
    // unknown register indexes must be ignored
    cfg_write(3'd5, '1);
    cfg_write(3'd7, '1);

    // random phases across key and round settings
    for (int ph = 0; ph < 10; ph++) begin
      cfg_write(CFG_W0, (ph == 1) ? 64'h0 : (ph == 2) ? '1 : rand64());
      cfg_write(CFG_W1, (ph == 1) ? 64'h0 : (ph == 2) ? '1 : rand64());
      cfg_write(CFG_CORE, (ph == 1) ? 64'h0 : (ph == 2) ? '1 : rand64());
      cfg_write(CFG_MIDDLE, (ph == 1) ? 64'h0 : (ph == 2) ? '1 : rand64());
      cfg_write(CFG_ROUNDS, 64'((ph == 0) ? 16 : (ph == 1) ? 1 : (ph == 2) ? 0 :
                $urandom_range(0, 31)));
      // final phase runs back to back with no idling
      if (ph == 9) noidle = 1'b1;
      queue_random(150);
      drain();
    end

    $display("encrypted %0d requests, checked %0d ciphertexts over 16 key and round settings",
             accepted, checked);
    if (mismatches == 0 && expected_cipher.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
